### rtl/core/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// Bellman-Ford unit package
// Widths, sizes, shared structs and the saturating add used by the core.
// ----------------------------------------------------------------------------
package bfsp_pkg;

   localparam int NUM_V  = 64;
   localparam int VERT_W = 6;
   localparam int NCNT_W = 7;
   localparam int NUM_E  = 1024;
   localparam int EDGE_W = 10;
   localparam int ECNT_W = 11;
   localparam int WGT_W  = 16;
   localparam int DIST_W = 32;

   localparam logic signed [DIST_W-1:0] DIST_NONE = 32'sh7fff_ffff;

   localparam logic CSR_VERTEX_COUNT  = 1'b0;
   localparam logic CSR_SOURCE_VERTEX = 1'b1;

   // Requests from the relaxation engine and the load side to the graph store.
   typedef struct packed {
      logic                    load;
      logic [VERT_W-1:0]       from;
      logic [VERT_W-1:0]       to;
      logic signed [WGT_W-1:0] weight;
      logic                    clear;
      logic [VERT_W-1:0]       rd_vertex;
      logic [EDGE_W-1:0]       rd_edge;
   } gs_ctrl_type;

   // Registered read data of the graph store.
   typedef struct packed {
      logic                    head_valid;
      logic [EDGE_W-1:0]       head;
      logic [EDGE_W-1:0]       tail;
      logic [VERT_W-1:0]       dest;
      logic signed [WGT_W-1:0] weight;
      logic [EDGE_W-1:0]       next;
   } gs_stat_type;

   function automatic logic signed [DIST_W-1:0] sat_add(
      input logic signed [DIST_W-1:0] a,
      input logic signed [WGT_W-1:0]  b
   );
      logic signed [DIST_W:0] s;
      s = {a[DIST_W-1], a} + {{(DIST_W-WGT_W+1){b[WGT_W-1]}}, b};
      if (s[DIST_W] != s[DIST_W-1]) begin
         sat_add = s[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : DIST_NONE;
      end else begin
         sat_add = s[DIST_W-1:0];
      end
   endfunction

endpackage

### rtl/core/bellman_ford_shortest_paths_unit.sv
// ----------------------------------------------------------------------------
// Bellman-Ford shortest paths unit
// Single-source shortest paths over a stream of directed weighted edges.
// ----------------------------------------------------------------------------
// Edges are taken one item per cycle while the unit is idle, and are linked
// into per-source lists. The item that carries tlast starts the run: the
// distances are initialized one vertex at a time, then n-1 relaxation passes
// and one check pass visit every vertex and walk the edges of each reached
// source (no compare when the destination is out of range); the check pass
// ends at its first improvement. One result item per vertex then follows, and
// edge items are taken again after the last result.
module bellman_ford_shortest_paths_unit
   import bfsp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [5:0] edge_from, [11:6] edge_to, [27:12] edge_weight, [31:28] zero
   input  logic [31:0]   req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [5:0] vertex_index, [37:6] distance, [38] reached, [44:39] predecessor,
   // [45] negative_cycle, [47:46] zero
   output logic [47:0]   rsp_tdata,
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [6:0]    csr_wdata
);

   logic [NCNT_W-1:0]        vcount_ff;
   logic [VERT_W-1:0]        src_ff;
   logic [NCNT_W-1:0]        n_eff;
   logic                     idle;
   logic                     accept;
   gs_ctrl_type              gs_ctrl;
   gs_stat_type              gs_stat;
   logic                     gs_clear;
   logic [VERT_W-1:0]        gs_vertex;
   logic [EDGE_W-1:0]        gs_edge;
   logic [VERT_W-1:0]        r_vertex;
   logic signed [DIST_W-1:0] r_dist;
   logic                     r_reached;
   logic [VERT_W-1:0]        r_pred;
   logic                     r_negcyc;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= NCNT_W'(1);
         src_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:  vcount_ff <= csr_wdata;
            CSR_SOURCE_VERTEX: src_ff    <= csr_wdata[VERT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (vcount_ff == '0) begin
         n_eff = NCNT_W'(1);
      end else if (vcount_ff > NCNT_W'(NUM_V)) begin
         n_eff = NCNT_W'(NUM_V);
      end else begin
         n_eff = vcount_ff;
      end
   end

   assign req_tready = idle;
   assign accept     = req_tvalid && idle;

   assign gs_ctrl.load      = accept;
   assign gs_ctrl.from      = req_tdata[5:0];
   assign gs_ctrl.to        = req_tdata[11:6];
   assign gs_ctrl.weight    = req_tdata[27:12];
   assign gs_ctrl.clear     = gs_clear;
   assign gs_ctrl.rd_vertex = gs_vertex;
   assign gs_ctrl.rd_edge   = gs_edge;

   bfsp_graph_store u_graph (
      .clock (clock),
      .reset (reset),
      .ctrl  (gs_ctrl),
      .stat  (gs_stat)
   );

   bfsp_relax_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && req_tlast),
      .n            (n_eff),
      .src          (src_ff),
      .idle         (idle),
      .gs           (gs_stat),
      .gs_clear     (gs_clear),
      .gs_vertex    (gs_vertex),
      .gs_edge      (gs_edge),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_vertex   (r_vertex),
      .rsp_distance (r_dist),
      .rsp_reached  (r_reached),
      .rsp_pred     (r_pred),
      .rsp_negcyc   (r_negcyc),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, r_negcyc, r_pred, r_reached, r_dist, r_vertex};

endmodule

### rtl/core/bfsp_graph_store.sv
// ----------------------------------------------------------------------------
// Graph store
// Edge memories and per-source list heads and tails, filled in arrival order.
// ----------------------------------------------------------------------------
module bfsp_graph_store
   import bfsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  gs_ctrl_type ctrl,
   output gs_stat_type stat
);

   logic [VERT_W+WGT_W-1:0] edge_mem [NUM_E];
   logic [EDGE_W-1:0]       next_mem [NUM_E];
   logic [EDGE_W-1:0]       head_mem [NUM_V];
   logic [EDGE_W-1:0]       tail_mem [NUM_V];

   logic [NUM_V-1:0]        hv_ff, hv_in;
   logic [ECNT_W-1:0]       cnt_ff, cnt_in;
   logic                    link_ff, link_in;
   logic [EDGE_W-1:0]       link_edge_ff;
   logic [EDGE_W-1:0]       tail_rd_ff;
   logic [EDGE_W-1:0]       head_rd_ff;
   logic                    hv_rd_ff;
   logic [VERT_W+WGT_W-1:0] edge_rd_ff;
   logic [EDGE_W-1:0]       next_rd_ff;
   logic                    store;
   logic [VERT_W-1:0]       vaddr;
   logic [EDGE_W-1:0]       slot;

   assign store = ctrl.load && (cnt_ff < ECNT_W'(NUM_E));
   assign vaddr = ctrl.load ? ctrl.from : ctrl.rd_vertex;
   assign slot  = cnt_ff[EDGE_W-1:0];

   always_comb begin
      hv_in   = hv_ff;
      cnt_in  = cnt_ff;
      link_in = store && hv_ff[ctrl.from];
      if (store) begin
         hv_in[ctrl.from] = 1'b1;
         cnt_in           = cnt_ff + 1'b1;
      end
      if (ctrl.clear) begin
         hv_in  = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff   <= '0;
         cnt_ff  <= '0;
         link_ff <= 1'b0;
      end else begin
         hv_ff   <= hv_in;
         cnt_ff  <= cnt_in;
         link_ff <= link_in;
      end
   end

   // The tail read returns the old tail while the new one is written, so the
   // link to the new edge goes into the previous tail in the following cycle.
   always_ff @(posedge clock) begin
      link_edge_ff <= slot;
      tail_rd_ff   <= tail_mem[vaddr];
      head_rd_ff   <= head_mem[vaddr];
      hv_rd_ff     <= hv_ff[vaddr];
      if (store) begin
         tail_mem[ctrl.from] <= slot;
         edge_mem[slot]      <= {ctrl.to, ctrl.weight};
         if (!hv_ff[ctrl.from]) begin
            head_mem[ctrl.from] <= slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      edge_rd_ff <= edge_mem[ctrl.rd_edge];
      next_rd_ff <= next_mem[ctrl.rd_edge];
      if (link_ff) begin
         next_mem[tail_rd_ff] <= link_edge_ff;
      end
   end

   assign stat.head_valid = hv_rd_ff;
   assign stat.head       = head_rd_ff;
   assign stat.tail       = tail_rd_ff;
   assign stat.dest       = edge_rd_ff[VERT_W+WGT_W-1:WGT_W];
   assign stat.weight     = edge_rd_ff[WGT_W-1:0];
   assign stat.next       = next_rd_ff;

endmodule

### rtl/core/bfsp_relax_engine.sv
// ----------------------------------------------------------------------------
// Relaxation engine
// Distance memory, pass sequencer and result register.
// ----------------------------------------------------------------------------
module bfsp_relax_engine
   import bfsp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NCNT_W-1:0]        n,
   input  logic [VERT_W-1:0]        src,
   output logic                     idle,
   input  gs_stat_type              gs,
   output logic                     gs_clear,
   output logic [VERT_W-1:0]        gs_vertex,
   output logic [EDGE_W-1:0]        gs_edge,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [VERT_W-1:0]        rsp_vertex,
   output logic signed [DIST_W-1:0] rsp_distance,
   output logic                     rsp_reached,
   output logic [VERT_W-1:0]        rsp_pred,
   output logic                     rsp_negcyc,
   output logic                     rsp_last
);

   typedef enum logic [9:0] {
      S_LOAD    = 10'b00_0000_0001,
      S_INIT    = 10'b00_0000_0010,
      S_SRC     = 10'b00_0000_0100,
      S_SRCD    = 10'b00_0000_1000,
      S_EDGE_RD = 10'b00_0001_0000,
      S_EDGE    = 10'b00_0010_0000,
      S_CMP     = 10'b00_0100_0000,
      S_OUT     = 10'b00_1000_0000,
      S_OUTD    = 10'b01_0000_0000,
      S_OUTH    = 10'b10_0000_0000
   } state_type;

   logic signed [DIST_W-1:0] dist_mem [NUM_V];
   logic [VERT_W-1:0]        pred_mem [NUM_V];

   state_type                state_ff, state_in;
   logic [VERT_W-1:0]        u_ff, u_in;
   logic [NCNT_W-1:0]        pass_ff, pass_in;
   logic [EDGE_W-1:0]        e_ff, e_in;
   logic signed [DIST_W-1:0] du_ff, du_in;
   logic                     flag_ff, flag_in;
   logic signed [DIST_W-1:0] dist_rd_ff;
   logic [VERT_W-1:0]        pred_rd_ff;
   logic [VERT_W-1:0]        daddr;
   logic                     wr_en;
   logic signed [DIST_W-1:0] wr_dist;
   logic [VERT_W-1:0]        wr_pred;
   logic [VERT_W-1:0]        wr_addr;
   logic signed [DIST_W-1:0] sum;
   logic                     u_last;
   logic                     check;
   logic                     src_ok;
   logic                     next_src;
   logic                     advance;
   logic [VERT_W-1:0]        rv_ff;
   logic signed [DIST_W-1:0] rd_ff;
   logic [VERT_W-1:0]        rp_ff;
   logic                     rl_ff;

   assign u_last = ({1'b0, u_ff} + 1'b1) == n;
   assign check  = pass_ff == n;
   assign src_ok = {1'b0, src} < n;
   assign sum    = sat_add(du_ff, gs.weight);

   always_comb begin
      state_in = state_ff;
      u_in     = u_ff;
      pass_in  = pass_ff;
      e_in     = e_ff;
      du_in    = du_ff;
      flag_in  = flag_ff;
      daddr    = u_ff;
      wr_en    = 1'b0;
      wr_addr  = u_ff;
      wr_dist  = DIST_NONE;
      wr_pred  = '0;
      gs_clear = 1'b0;
      next_src = 1'b0;
      advance  = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (start) begin
               u_in     = '0;
               flag_in  = 1'b0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            wr_en   = 1'b1;
            wr_dist = (src_ok && u_ff == src) ? '0 : DIST_NONE;
            if (u_last) begin
               u_in     = '0;
               pass_in  = NCNT_W'(1);
               state_in = S_SRC;
            end else begin
               u_in = u_ff + 1'b1;
            end
         end
         S_SRC: begin
            state_in = S_SRCD;
         end
         S_SRCD: begin
            du_in = dist_rd_ff;
            if (gs.head_valid && dist_rd_ff != DIST_NONE) begin
               e_in     = gs.head;
               state_in = S_EDGE_RD;
            end else begin
               next_src = 1'b1;
            end
         end
         S_EDGE_RD: begin
            state_in = S_EDGE;
         end
         S_EDGE: begin
            daddr = gs.dest;
            if ({1'b0, gs.dest} < n) begin
               state_in = S_CMP;
            end else begin
               advance = 1'b1;
            end
         end
         S_CMP: begin
            advance = 1'b1;
            if (sum < dist_rd_ff) begin
               if (check) begin
                  flag_in  = 1'b1;
                  advance  = 1'b0;
                  u_in     = '0;
                  state_in = S_OUT;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = gs.dest;
                  wr_dist = sum;
                  wr_pred = u_ff;
                  // A self loop changes the distance of the current source.
                  if (gs.dest == u_ff) begin
                     du_in = sum;
                  end
               end
            end
         end
         S_OUT: begin
            state_in = S_OUTD;
         end
         S_OUTD: begin
            state_in = S_OUTH;
         end
         S_OUTH: begin
            if (rsp_ready) begin
               if (u_last) begin
                  gs_clear = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  u_in     = u_ff + 1'b1;
                  state_in = S_OUT;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase

      if (advance) begin
         if (e_ff == gs.tail) begin
            next_src = 1'b1;
         end else begin
            e_in     = gs.next;
            state_in = S_EDGE_RD;
         end
      end
      if (next_src) begin
         if (u_last) begin
            u_in = '0;
            if (check) begin
               state_in = S_OUT;
            end else begin
               pass_in  = pass_ff + 1'b1;
               state_in = S_SRC;
            end
         end else begin
            u_in     = u_ff + 1'b1;
            state_in = S_SRC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      pass_ff <= pass_in;
      e_ff    <= e_in;
      du_ff   <= du_in;
   end

   always_ff @(posedge clock) begin
      dist_rd_ff <= dist_mem[daddr];
      pred_rd_ff <= pred_mem[daddr];
      if (wr_en) begin
         dist_mem[wr_addr] <= wr_dist;
         pred_mem[wr_addr] <= wr_pred;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUTD) begin
         rv_ff <= u_ff;
         rd_ff <= dist_rd_ff;
         rp_ff <= pred_rd_ff;
         rl_ff <= u_last;
      end
   end

   assign idle         = state_ff == S_LOAD;
   assign gs_vertex    = u_ff;
   assign gs_edge      = e_ff;
   assign rsp_valid    = state_ff == S_OUTH;
   assign rsp_vertex   = rv_ff;
   assign rsp_distance = rd_ff;
   assign rsp_reached  = rd_ff != DIST_NONE;
   assign rsp_pred     = rp_ff;
   assign rsp_negcyc   = flag_ff;
   assign rsp_last     = rl_ff;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Bellman-Ford shortest paths unit testbench
// Streams graphs of directed weighted edges into the unit, predicts the
// per-vertex distances, reach flags, predecessors and negative cycle flag,
// and compares every result item field by field, with random idling on both
// sides and changes of vertex count and source between graphs.
// ----------------------------------------------------------------------------
module tb_top;
   import bfsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [5:0]         vidx;
      logic signed [31:0] dval;
      logic               reached;
      logic [5:0]         pred;
      logic               neg;
      logic               last;
   } vertex_result_type;

   typedef struct {
      logic               set_cfg;
      logic [6:0]         n;
      logic [5:0]         src;
      logic [5:0]         from;
      logic [5:0]         to;
      logic signed [15:0] w;
      logic               last;
      logic               chk;
      logic signed [31:0] xd;
      logic               xr;
      logic               xneg;
   } edge_row_type;

   localparam int ROWS = 14;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [6:0]  csr_wdata = '0;

   // Predictor state: the graph being loaded and the current settings.
   logic [5:0]         gr_from [NUM_E];
   logic [5:0]         gr_to [NUM_E];
   logic signed [15:0] gr_w [NUM_E];
   int                 gr_count = 0;
   logic [6:0]         set_n = 7'd1;
   logic [5:0]         set_src = 6'd0;
   logic signed [31:0] pr_dist [NUM_V];
   logic [5:0]         pr_pred [NUM_V];

   vertex_result_type expected_q [$];
   edge_row_type      rows [ROWS];
   int                errors = 0;
   int                idle_pct = 6;
   int                items = 0;

   bellman_ford_shortest_paths_unit i_dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   function automatic logic signed [31:0] sum_sat(logic signed [31:0] a,
                                                  logic signed [15:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > 64'sd2147483647) return 32'sh7fff_ffff;
      if (s < -64'sd2147483648) return 32'sh8000_0000;
      return s[31:0];
   endfunction

   // One sweep in source order, each source's edges in arrival order.
   function automatic bit relax_sweep(int n, bit do_relax);
      logic signed [31:0] s;
      int v;
      for (int u = 0; u < n; u++) begin
         for (int e = 0; e < gr_count; e++) begin
            if (gr_from[e] == u) begin
               v = gr_to[e];
               if (v < n && pr_dist[u] != DIST_NONE) begin
                  s = sum_sat(pr_dist[u], gr_w[e]);
                  if (s < pr_dist[v]) begin
                     if (!do_relax) return 1'b1;
                     pr_dist[v] = s;
                     pr_pred[v] = u[5:0];
                  end
               end
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic void predict_paths();
      int n;
      bit neg;
      vertex_result_type r;
      n = set_n;
      if (n < 1) n = 1;
      if (n > NUM_V) n = NUM_V;
      for (int v = 0; v < n; v++) begin
         pr_dist[v] = DIST_NONE;
         pr_pred[v] = '0;
      end
      if (set_src < n) pr_dist[set_src] = 0;
      for (int p = 1; p < n; p++) void'(relax_sweep(n, 1'b1));
      neg = relax_sweep(n, 1'b0);
      for (int v = 0; v < n; v++) begin
         r.vidx = v[5:0];
         r.dval = pr_dist[v];
         r.reached = (pr_dist[v] != DIST_NONE);
         r.pred = pr_pred[v];
         r.neg = neg;
         r.last = (v + 1 == n);
         expected_q.push_back(r);
      end
   endfunction

   // Called at a rising edge; leaves the edge accepted at that same edge.
   task automatic send_edge(logic [5:0] from, logic [5:0] to, logic signed [15:0] w,
                            logic last, logic typed, vertex_result_type typed_res);
      logic rdy;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, w, to, from};
      req_tlast  <= last;
      do begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
      end while (!rdy);
      items++;
      if (gr_count < NUM_E) begin
         gr_from[gr_count] = from;
         gr_to[gr_count] = to;
         gr_w[gr_count] = w;
         gr_count++;
      end
      if (last) begin
         if (typed) expected_q.push_back(typed_res);
         else predict_paths();
         gr_count = 0;
      end
   endtask

   // Settings change only once the unit has drained its results.
   task automatic write_settings(logic [6:0] n, logic [5:0] src);
      req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (20) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_VERTEX_COUNT;
      csr_wdata <= n;
      @(posedge clock);
      csr_index <= CSR_SOURCE_VERTEX;
      csr_wdata <= {1'b0, src};
      @(posedge clock);
      csr_we <= 1'b0;
      set_n = n;
      set_src = src;
   endtask

   always @(negedge clock) begin
      vertex_result_type x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected item %h last %b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            x = expected_q.pop_front();
            if (rsp_tdata[5:0] !== x.vidx) begin
               $display("%0t: vertex_index exp %0d got %0d", $time, x.vidx, rsp_tdata[5:0]);
               errors++;
            end
            if ($signed(rsp_tdata[37:6]) !== x.dval) begin
               $display("%0t: distance v%0d exp %0d got %0d", $time, x.vidx, x.dval,
                        $signed(rsp_tdata[37:6]));
               errors++;
            end
            if (rsp_tdata[38] !== x.reached) begin
               $display("%0t: reached v%0d exp %b got %b", $time, x.vidx, x.reached,
                        rsp_tdata[38]);
               errors++;
            end
            if (rsp_tdata[44:39] !== x.pred) begin
               $display("%0t: predecessor v%0d exp %0d got %0d", $time, x.vidx, x.pred,
                        rsp_tdata[44:39]);
               errors++;
            end
            if (rsp_tdata[45] !== x.neg) begin
               $display("%0t: negative_cycle v%0d exp %b got %b", $time, x.vidx, x.neg,
                        rsp_tdata[45]);
               errors++;
            end
            if (rsp_tlast !== x.last) begin
               $display("%0t: last_vertex v%0d exp %b got %b", $time, x.vidx, x.last,
                        rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("tb_top failed");
      $finish;
   end

   initial begin
      vertex_result_type tr;
      int n, src, ne, g;
      logic [5:0] f, t;
      logic signed [15:0] w;

      //        cfg  n       src    from   to     w          last chk xd          xr   xneg
      rows[0]  = '{0, 7'd0,  6'd0,  6'd0,  6'd0,  16'sd5,    1, 1, 32'sd0,     1, 0};
      // A negative self loop on a single vertex still improves in the check pass.
      rows[1]  = '{1, 7'd1,  6'd0,  6'd0,  6'd0,  -16'sd1,   1, 1, 32'sd0,     1, 1};
      rows[2]  = '{1, 7'd0,  6'd0,  6'd63, 6'd63, 16'sh8000, 1, 1, 32'sd0,     1, 0};
      rows[3]  = '{1, 7'd1,  6'd5,  6'd0,  6'd0,  16'sd1,    1, 1, DIST_NONE,  0, 0};
      rows[4]  = '{1, 7'd127, 6'd63, 6'd63, 6'd0, 16'sh8000, 0, 0, 0, 0, 0};
      rows[5]  = '{0, 7'd0,  6'd0,  6'd0,  6'd63, 16'sd32767, 0, 0, 0, 0, 0};
      rows[6]  = '{0, 7'd0,  6'd0,  6'd62, 6'd0,  16'sd1,    0, 0, 0, 0, 0};
      rows[7]  = '{0, 7'd0,  6'd0,  6'd0,  6'd1,  16'sd32767, 0, 0, 0, 0, 0};
      rows[8]  = '{0, 7'd0,  6'd0,  6'd1,  6'd2,  -16'sd100, 1, 0, 0, 0, 0};
      rows[9]  = '{1, 7'd64, 6'd0,  6'd0,  6'd1,  -16'sd5,   0, 0, 0, 0, 0};
      rows[10] = '{0, 7'd0,  6'd0,  6'd1,  6'd0,  16'sd2,    1, 0, 0, 0, 0};
      rows[11] = '{1, 7'd3,  6'd2,  6'd2,  6'd40, 16'sd7,    0, 0, 0, 0, 0};
      rows[12] = '{0, 7'd0,  6'd0,  6'd2,  6'd0,  16'sd9,    0, 0, 0, 0, 0};
      rows[13] = '{0, 7'd0,  6'd0,  6'd9,  6'd1,  16'sd3,    1, 0, 0, 0, 0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < ROWS; i++) begin
         if (rows[i].set_cfg) write_settings(rows[i].n, rows[i].src);
         tr.vidx = '0;
         tr.dval = rows[i].xd;
         tr.reached = rows[i].xr;
         tr.pred = '0;
         tr.neg = rows[i].xneg;
         tr.last = 1'b1;
         send_edge(rows[i].from, rows[i].to, rows[i].w, rows[i].last, rows[i].chk, tr);
      end

      g = 0;
      while (items < 410) begin
         idle_pct = (g >= 6 && g < 10) ? 0 : 6;
         case ($urandom_range(9))
            0: n = NUM_V;
            1: n = 1;
            2: n = $urandom_range(127, 65);
            default: n = $urandom_range(12, 2);
         endcase
         src = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(n > 64 ? 63 : n - 1);
         write_settings(n[6:0], src[5:0]);
         ne = (n >= NUM_V) ? $urandom_range(12, 1) : $urandom_range(30, 1);
         for (int e = 0; e < ne; e++) begin
            if (n > 64) n = 64;
            if ($urandom_range(9) == 0) begin
               f = $urandom_range(63);
               t = $urandom_range(63);
            end else begin
               f = $urandom_range(n - 1);
               t = $urandom_range(n - 1);
            end
            case ($urandom_range(9))
               0: w = $urandom_range(16'hffff);
               1: w = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
               default: w = $urandom_range(120) - 20;
            endcase
            send_edge(f, t, w, e == ne - 1, 1'b0, tr);
         end
         g++;
      end
      req_tvalid <= 1'b0;

      wait (expected_q.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
